### rtl/rational_cubic_uv_evaluator_assert.svh
// assertion macros for the rational cubic uv evaluator
`ifndef RATIONAL_CUBIC_UV_EVALUATOR_ASSERT_SVH
`define RATIONAL_CUBIC_UV_EVALUATOR_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define RCUV_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// implication after a fixed number of cycles
`define RCUV_ASSERT_AFTER(label, clk, rst_n, ante, n, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error(msg);
`else
`define RCUV_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define RCUV_ASSERT_AFTER(label, clk, rst_n, ante, n, cons, msg)
`endif
`endif

### rtl/rcuv_pkg.sv
package rcuv_pkg;

    // fixed field widths
    localparam int COEF_W     = 32;
    localparam int POLY_W     = 36;
    localparam int QUOT_W     = 32;
    localparam int MUL_CHUNK  = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int STATUS_W   = 2;

    // pipeline latencies of the units
    localparam int HORNER_LAT = 3;
    localparam int MUL_LAT    = 2;
    localparam int DIV_LAT    = QUOT_W + 3;

    localparam logic [QUOT_W-1:0] QUOT_MAX = {1'b0, {(QUOT_W-1){1'b1}}};
    localparam logic [QUOT_W-1:0] QUOT_MIN = {1'b1, {(QUOT_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SEG_FLAG = 3'd0,
        REG_X_LO     = 3'd1,
        REG_X_HI     = 3'd2,
        REG_Y_LO     = 3'd3,
        REG_Y_HI     = 3'd4,
        REG_W_LO     = 3'd5,
        REG_W_HI     = 3'd6
    } cfg_reg_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK     = 2'd0,
        STATUS_NOT_UV = 2'd1,
        STATUS_ZERO_W = 2'd2,
        STATUS_SAT    = 2'd3
    } status_t;

    // divider result word
    typedef struct packed {
        logic [QUOT_W-1:0] value;
        logic              sat;
    } quot_t;

endpackage

### rtl/rcuv_delay.sv
module rcuv_delay
    import rcuv_pkg::*;
#(
    parameter int W     = 1,
    parameter int DEPTH = 1
)
(
    input  logic         clk,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] stage_reg [DEPTH];

    // shift line
    always_ff @(posedge clk)
    begin
        stage_reg[0] <= din;
        for (int i = 1; i < DEPTH; i++)
        begin
            stage_reg[i] <= stage_reg[i-1];
        end
    end

    assign dout = stage_reg[DEPTH-1];

endmodule

### rtl/rcuv_horner.sv
module rcuv_horner
    import rcuv_pkg::*;
#(
    parameter int PF = 16
)
(
    input  logic                     clk,
    input  logic [PF:0]              t,
    input  logic signed [COEF_W-1:0] c0,
    input  logic signed [COEF_W-1:0] c1,
    input  logic signed [COEF_W-1:0] c2,
    input  logic signed [COEF_W-1:0] c3,
    output logic signed [POLY_W-1:0] p0,
    output logic signed [POLY_W-1:0] p1,
    output logic signed [POLY_W-1:0] p2
);

    localparam int PRD_W = POLY_W + PF + 2;
    localparam logic signed [PRD_W-1:0] RND = PRD_W'(1) <<< (PF - 1);
    localparam logic [PF:0] T_ONE = {1'b1, {PF{1'b0}}};

    logic [PF:0]              t_clamp;
    logic signed [POLY_W-1:0] c0x, c1x, c2x, c3x;
    logic [PF:0]              t1_reg, t2_reg;
    logic signed [POLY_W-1:0] m1_reg, d1_reg, m2_reg, d2_reg;
    logic signed [POLY_W-1:0] p2a_reg, p2b_reg;
    logic signed [POLY_W-1:0] p0_reg, p1_reg, p2_reg;

    // v * t rounded half up to the coefficient scale
    function automatic logic signed [POLY_W-1:0] tmul(input logic signed [POLY_W-1:0] v,
                                                     input logic [PF:0] tv);
        logic signed [PRD_W-1:0] prod;
        prod = v * $signed({1'b0, tv});
        prod = prod + RND;
        return POLY_W'(prod >>> PF);
    endfunction

    assign t_clamp = (t > T_ONE) ? T_ONE : t;
    assign c0x = POLY_W'(c0);
    assign c1x = POLY_W'(c1);
    assign c2x = POLY_W'(c2);
    assign c3x = POLY_W'(c3);

    // three horner steps
    always_ff @(posedge clk)
    begin
        t1_reg  <= t_clamp;
        m1_reg  <= tmul(c3x, t_clamp);
        d1_reg  <= tmul(c3x + (c3x <<< 1), t_clamp);
        p2a_reg <= (c2x <<< 1) + tmul((c3x <<< 1) + (c3x <<< 2), t_clamp);

        t2_reg  <= t1_reg;
        m2_reg  <= tmul(c2x + m1_reg, t1_reg);
        d2_reg  <= tmul((c2x <<< 1) + d1_reg, t1_reg);
        p2b_reg <= p2a_reg;

        p0_reg  <= c0x + tmul(c1x + m2_reg, t2_reg);
        p1_reg  <= c1x + d2_reg;
        p2_reg  <= p2b_reg;
    end

    assign p0 = p0_reg;
    assign p1 = p1_reg;
    assign p2 = p2_reg;

endmodule

### rtl/rcuv_mul.sv
module rcuv_mul
    import rcuv_pkg::*;
#(
    parameter int A_W = 36,
    parameter int B_W = 36
)
(
    input  logic                      clk,
    input  logic signed [A_W-1:0]     a,
    input  logic signed [B_W-1:0]     b,
    output logic signed [A_W+B_W-1:0] p
);

    localparam int NA = (A_W + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int NB = (B_W + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int PW = A_W + B_W;

    logic [A_W-1:0]           a_mag;
    logic [B_W-1:0]           b_mag;
    logic [NA*MUL_CHUNK-1:0]  a_pad;
    logic [NB*MUL_CHUNK-1:0]  b_pad;
    logic [2*MUL_CHUNK-1:0]   pp_reg [NA*NB];
    logic                     neg_reg;
    logic [PW-1:0]            mag_sum;
    logic signed [PW-1:0]     p_reg;

    // sign and magnitude
    assign a_mag = a[A_W-1] ? A_W'(-a) : A_W'(a);
    assign b_mag = b[B_W-1] ? B_W'(-b) : B_W'(b);
    assign a_pad = (NA*MUL_CHUNK)'(a_mag);
    assign b_pad = (NB*MUL_CHUNK)'(b_mag);

    // partial products of 32-bit chunks
    always_ff @(posedge clk)
    begin
        neg_reg <= a[A_W-1] ^ b[B_W-1];
        for (int i = 0; i < NA; i++)
        begin
            for (int j = 0; j < NB; j++)
            begin
                pp_reg[i*NB+j] <= (2*MUL_CHUNK)'(a_pad[i*MUL_CHUNK +: MUL_CHUNK])
                                * (2*MUL_CHUNK)'(b_pad[j*MUL_CHUNK +: MUL_CHUNK]);
            end
        end
    end

    // sum of shifted partials
    always_comb
    begin
        mag_sum = '0;
        for (int i = 0; i < NA; i++)
        begin
            for (int j = 0; j < NB; j++)
            begin
                mag_sum = mag_sum + (PW'(pp_reg[i*NB+j]) << ((i + j) * MUL_CHUNK));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg <= neg_reg ? $signed(PW'(-mag_sum)) : $signed(mag_sum);
    end

    assign p = p_reg;

endmodule

### rtl/rcuv_div.sv
module rcuv_div
    import rcuv_pkg::*;
#(
    parameter int N_W = 36,
    parameter int D_W = 36,
    parameter int CF  = 16
)
(
    input  logic                  clk,
    input  logic signed [N_W-1:0] n,
    input  logic signed [D_W-1:0] d,
    output quot_t                 q
);

    localparam int SHIFT_W = N_W + CF + 1;
    localparam int LIM_W   = D_W + QUOT_W + 1;
    localparam int XW      = (SHIFT_W > LIM_W) ? SHIFT_W : LIM_W;

    logic [N_W-1:0]    n_mag;
    logic [D_W-1:0]    d_mag;
    logic [XW-1:0]     num_prep_reg;
    logic [D_W-1:0]    den_prep_reg;
    logic              neg_prep_reg;
    logic [XW-1:0]     sat_lim;
    logic [XW-1:0]     rem_reg [QUOT_W+1];
    logic [D_W-1:0]    den_reg [QUOT_W+1];
    logic [QUOT_W-1:0] quo_reg [QUOT_W+1];
    logic              neg_reg [QUOT_W+1];
    logic              sat_reg [QUOT_W+1];
    quot_t             result_next;
    quot_t             result_reg;

    assign n_mag = n[N_W-1] ? N_W'(-n) : N_W'(n);
    assign d_mag = d[D_W-1] ? D_W'(-d) : D_W'(d);

    // scaled numerator plus half the divisor for rounding
    always_ff @(posedge clk)
    begin
        num_prep_reg <= (XW'(n_mag) << CF) + XW'(d_mag >> 1);
        den_prep_reg <= d_mag;
        neg_prep_reg <= n[N_W-1] ^ d[D_W-1];
    end

    // quotient past the limit when numerator reaches (limit + 1) * divisor
    assign sat_lim = (XW'(den_prep_reg) << (QUOT_W - 1))
                   + (neg_prep_reg ? XW'(den_prep_reg) : XW'(0));

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= num_prep_reg;
        den_reg[0] <= den_prep_reg;
        quo_reg[0] <= '0;
        neg_reg[0] <= neg_prep_reg;
        sat_reg[0] <= (num_prep_reg >= sat_lim);
    end

    // one restoring step per stage, msb first
    for (genvar k = 0; k < QUOT_W; k++)
    begin : g_step
        localparam int SH = QUOT_W - 1 - k;
        logic [XW-1:0] den_sh;
        logic          fits;

        assign den_sh = XW'(den_reg[k]) << SH;
        assign fits   = (rem_reg[k] >= den_sh);

        always_ff @(posedge clk)
        begin
            rem_reg[k+1] <= fits ? (rem_reg[k] - den_sh) : rem_reg[k];
            den_reg[k+1] <= den_reg[k];
            quo_reg[k+1] <= {quo_reg[k][QUOT_W-2:0], fits};
            neg_reg[k+1] <= neg_reg[k];
            sat_reg[k+1] <= sat_reg[k];
        end
    end

    // sign and saturation
    always_comb
    begin
        result_next.sat = sat_reg[QUOT_W];
        if (sat_reg[QUOT_W])
        begin
            result_next.value = neg_reg[QUOT_W] ? QUOT_MIN : QUOT_MAX;
        end
        else
        begin
            result_next.value = neg_reg[QUOT_W] ? QUOT_W'(-quo_reg[QUOT_W]) : quo_reg[QUOT_W];
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign q = result_reg;

endmodule

### rtl/rational_cubic_uv_evaluator.sv
// channel | signals                                     | accepted when
// --------+---------------------------------------------+------------------------------
// input   | start, busy, param_t                        | start high and busy low
// config  | cfg_valid, cfg_ready, cfg_index, cfg_data   | cfg_valid and cfg_ready high
// result  | done, u/v value, first/second deriv, status | done high, one cycle
//
// one word accepted per cycle; busy stays low and cfg_ready stays high
// done follows the accepting edge through 3 horner stages, two 2-stage
// multiplier levels, 2 adder stages, 35 divider stages (operand prep, saturation
// check, 32 quotient bits, sign) and the output register
// reset clears the valid line, done and the config registers
// no stall exists on either side: every accepted word comes out once
`include "rational_cubic_uv_evaluator_assert.svh"

module rational_cubic_uv_evaluator
    import rcuv_pkg::*;
#(
    parameter int COEF_FRAC_BITS  = 16,
    parameter int PARAM_FRAC_BITS = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [PARAM_FRAC_BITS:0]     param_t,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    output logic                         done,
    output logic signed [QUOT_W-1:0]     u_value,
    output logic signed [QUOT_W-1:0]     v_value,
    output logic signed [QUOT_W-1:0]     u_first_deriv,
    output logic signed [QUOT_W-1:0]     v_first_deriv,
    output logic signed [QUOT_W-1:0]     u_second_deriv,
    output logic signed [QUOT_W-1:0]     v_second_deriv,
    output logic [STATUS_W-1:0]          status
);

    // stage where each value is valid, counted from the accepting edge
    localparam int ST_POLY   = HORNER_LAT - 1;
    localparam int ST_PROD_A = ST_POLY + MUL_LAT;
    localparam int ST_N1     = ST_PROD_A + 1;
    localparam int ST_PROD_B = ST_PROD_A + MUL_LAT;
    localparam int ST_N2     = ST_PROD_B + 2;
    localparam int ST_DIV    = ST_N2 + DIV_LAT;
    localparam int P2_W      = 2 * POLY_W;
    localparam int P3_W      = 3 * POLY_W;

    logic                    accept;
    logic                    seg_flag_reg;
    logic [CFG_DATA_W-1:0]   x_lo_reg, x_hi_reg, y_lo_reg, y_hi_reg, w_lo_reg, w_hi_reg;
    logic [ST_DIV:0]         vld_reg;
    logic                    done_reg;

    logic signed [POLY_W-1:0] xp0, xp1, xp2, yp0, yp1, yp2, wp0, wp1, wp2;
    logic [8*POLY_W-1:0]      poly_dly;
    logic signed [POLY_W-1:0] x0a, x1a, x2a, y0a, y1a, y2a, w0a, w2a;

    logic signed [P2_W-1:0]   w0w0, w0x1, w1x0, w0y1, w1y0, w0x0, w0y0, w0w1, w1w1;
    logic signed [P2_W-1:0]   n1x_reg, n1y_reg;
    logic signed [P3_W-1:0]   w3, w2x2, w2y2, x0w0w2, y0w0w2, w0w1x1, w0w1y1, w1w1x0, w1w1y0;
    logic signed [P3_W-1:0]   sa_x_reg, sb_x_reg, sa_y_reg, sb_y_reg, n2x_reg, n2y_reg;

    logic [3*POLY_W+P2_W-1:0] den_dly;
    logic signed [POLY_W-1:0] x0n, y0n, w0n;
    logic signed [P2_W-1:0]   w0w0n;
    logic [2*P2_W-1:0]        n1_dly;
    logic signed [P2_W-1:0]   n1xn, n1yn;
    logic signed [P3_W-1:0]   w3n;
    logic                     zero_w_dly;

    quot_t                    uq0, vq0, uq1, vq1, uq2, vq2;
    logic                     sat_any;
    logic [STATUS_W-1:0]      status_next;
    logic [STATUS_W-1:0]      status_reg;
    logic                     zero_out;
    logic signed [QUOT_W-1:0] u_value_reg, v_value_reg, u_first_reg, v_first_reg;
    logic signed [QUOT_W-1:0] u_second_reg, v_second_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_flag_reg <= 1'b0;
            x_lo_reg     <= '0;
            x_hi_reg     <= '0;
            y_lo_reg     <= '0;
            y_hi_reg     <= '0;
            w_lo_reg     <= '0;
            w_hi_reg     <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SEG_FLAG: seg_flag_reg <= cfg_data[0];
                REG_X_LO:     x_lo_reg     <= cfg_data;
                REG_X_HI:     x_hi_reg     <= cfg_data;
                REG_Y_LO:     y_lo_reg     <= cfg_data;
                REG_Y_HI:     y_hi_reg     <= cfg_data;
                REG_W_LO:     w_lo_reg     <= cfg_data;
                REG_W_HI:     w_hi_reg     <= cfg_data;
                default:      ;
            endcase
        end
    end

    // valid line and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= {vld_reg[ST_DIV-1:0], accept};
            done_reg <= vld_reg[ST_DIV];
        end
    end

    // polynomials and derivatives
    rcuv_horner #(.PF(PARAM_FRAC_BITS)) u_horner_x (
        .clk(clk), .t(param_t),
        .c0(x_lo_reg[COEF_W-1:0]), .c1(x_lo_reg[2*COEF_W-1:COEF_W]),
        .c2(x_hi_reg[COEF_W-1:0]), .c3(x_hi_reg[2*COEF_W-1:COEF_W]),
        .p0(xp0), .p1(xp1), .p2(xp2)
    );

    rcuv_horner #(.PF(PARAM_FRAC_BITS)) u_horner_y (
        .clk(clk), .t(param_t),
        .c0(y_lo_reg[COEF_W-1:0]), .c1(y_lo_reg[2*COEF_W-1:COEF_W]),
        .c2(y_hi_reg[COEF_W-1:0]), .c3(y_hi_reg[2*COEF_W-1:COEF_W]),
        .p0(yp0), .p1(yp1), .p2(yp2)
    );

    rcuv_horner #(.PF(PARAM_FRAC_BITS)) u_horner_w (
        .clk(clk), .t(param_t),
        .c0(w_lo_reg[COEF_W-1:0]), .c1(w_lo_reg[2*COEF_W-1:COEF_W]),
        .c2(w_hi_reg[COEF_W-1:0]), .c3(w_hi_reg[2*COEF_W-1:COEF_W]),
        .p0(wp0), .p1(wp1), .p2(wp2)
    );

    // polynomial values held for the second product level
    rcuv_delay #(.W(8*POLY_W), .DEPTH(MUL_LAT)) u_dly_poly (
        .clk(clk),
        .din({xp0, xp1, xp2, yp0, yp1, yp2, wp0, wp2}),
        .dout(poly_dly)
    );

    assign {x0a, x1a, x2a, y0a, y1a, y2a, w0a, w2a} = poly_dly;

    // first product level
    rcuv_mul #(.A_W(POLY_W), .B_W(POLY_W)) u_mul_w0w0 (.clk(clk), .a(wp0), .b(wp0), .p(w0w0));
    rcuv_mul #(.A_W(POLY_W), .B_W(POLY_W)) u_mul_w0x1 (.clk(clk), .a(wp0), .b(xp1), .p(w0x1));
    rcuv_mul #(.A_W(POLY_W), .B_W(POLY_W)) u_mul_w1x0 (.clk(clk), .a(wp1), .b(xp0), .p(w1x0));
    rcuv_mul #(.A_W(POLY_W), .B_W(POLY_W)) u_mul_w0y1 (.clk(clk), .a(wp0), .b(yp1), .p(w0y1));
    rcuv_mul #(.A_W(POLY_W), .B_W(POLY_W)) u_mul_w1y0 (.clk(clk), .a(wp1), .b(yp0), .p(w1y0));
    rcuv_mul #(.A_W(POLY_W), .B_W(POLY_W)) u_mul_w0x0 (.clk(clk), .a(wp0), .b(xp0), .p(w0x0));
    rcuv_mul #(.A_W(POLY_W), .B_W(POLY_W)) u_mul_w0y0 (.clk(clk), .a(wp0), .b(yp0), .p(w0y0));
    rcuv_mul #(.A_W(POLY_W), .B_W(POLY_W)) u_mul_w0w1 (.clk(clk), .a(wp0), .b(wp1), .p(w0w1));
    rcuv_mul #(.A_W(POLY_W), .B_W(POLY_W)) u_mul_w1w1 (.clk(clk), .a(wp1), .b(wp1), .p(w1w1));

    // first derivative numerators
    always_ff @(posedge clk)
    begin
        n1x_reg <= w0x1 - w1x0;
        n1y_reg <= w0y1 - w1y0;
    end

    // second product level
    rcuv_mul #(.A_W(P2_W), .B_W(POLY_W)) u_mul_w3 (.clk(clk), .a(w0w0), .b(w0a), .p(w3));
    rcuv_mul #(.A_W(P2_W), .B_W(POLY_W)) u_mul_w2x2 (.clk(clk), .a(w0w0), .b(x2a), .p(w2x2));
    rcuv_mul #(.A_W(P2_W), .B_W(POLY_W)) u_mul_w2y2 (.clk(clk), .a(w0w0), .b(y2a), .p(w2y2));
    rcuv_mul #(.A_W(P2_W), .B_W(POLY_W)) u_mul_xww (.clk(clk), .a(w0x0), .b(w2a), .p(x0w0w2));
    rcuv_mul #(.A_W(P2_W), .B_W(POLY_W)) u_mul_yww (.clk(clk), .a(w0y0), .b(w2a), .p(y0w0w2));
    rcuv_mul #(.A_W(P2_W), .B_W(POLY_W)) u_mul_wwx1 (.clk(clk), .a(w0w1), .b(x1a), .p(w0w1x1));
    rcuv_mul #(.A_W(P2_W), .B_W(POLY_W)) u_mul_wwy1 (.clk(clk), .a(w0w1), .b(y1a), .p(w0w1y1));
    rcuv_mul #(.A_W(P2_W), .B_W(POLY_W)) u_mul_w11x (.clk(clk), .a(w1w1), .b(x0a), .p(w1w1x0));
    rcuv_mul #(.A_W(P2_W), .B_W(POLY_W)) u_mul_w11y (.clk(clk), .a(w1w1), .b(y0a), .p(w1w1y0));

    // second derivative numerators in two adder stages
    always_ff @(posedge clk)
    begin
        sa_x_reg <= w2x2 - x0w0w2;
        sb_x_reg <= (w1w1x0 - w0w1x1) <<< 1;
        sa_y_reg <= w2y2 - y0w0w2;
        sb_y_reg <= (w1w1y0 - w0w1y1) <<< 1;
        n2x_reg  <= sa_x_reg + sb_x_reg;
        n2y_reg  <= sa_y_reg + sb_y_reg;
    end

    // align divider operands
    rcuv_delay #(.W(3*POLY_W+P2_W), .DEPTH(ST_N2-ST_PROD_A)) u_dly_den (
        .clk(clk), .din({x0a, y0a, w0a, w0w0}), .dout(den_dly)
    );

    assign {x0n, y0n, w0n, w0w0n} = den_dly;

    rcuv_delay #(.W(2*P2_W), .DEPTH(ST_N2-ST_N1)) u_dly_n1 (
        .clk(clk), .din({n1x_reg, n1y_reg}), .dout(n1_dly)
    );

    assign {n1xn, n1yn} = n1_dly;

    rcuv_delay #(.W(P3_W), .DEPTH(ST_N2-ST_PROD_B)) u_dly_w3 (
        .clk(clk), .din(w3), .dout(w3n)
    );

    rcuv_delay #(.W(1), .DEPTH(ST_DIV-ST_POLY)) u_dly_zero (
        .clk(clk), .din(wp0 == '0), .dout(zero_w_dly)
    );

    // six quotients
    rcuv_div #(.N_W(POLY_W), .D_W(POLY_W), .CF(COEF_FRAC_BITS)) u_div_u0 (
        .clk(clk), .n(x0n), .d(w0n), .q(uq0)
    );
    rcuv_div #(.N_W(POLY_W), .D_W(POLY_W), .CF(COEF_FRAC_BITS)) u_div_v0 (
        .clk(clk), .n(y0n), .d(w0n), .q(vq0)
    );
    rcuv_div #(.N_W(P2_W), .D_W(P2_W), .CF(COEF_FRAC_BITS)) u_div_u1 (
        .clk(clk), .n(n1xn), .d(w0w0n), .q(uq1)
    );
    rcuv_div #(.N_W(P2_W), .D_W(P2_W), .CF(COEF_FRAC_BITS)) u_div_v1 (
        .clk(clk), .n(n1yn), .d(w0w0n), .q(vq1)
    );
    rcuv_div #(.N_W(P3_W), .D_W(P3_W), .CF(COEF_FRAC_BITS)) u_div_u2 (
        .clk(clk), .n(n2x_reg), .d(w3n), .q(uq2)
    );
    rcuv_div #(.N_W(P3_W), .D_W(P3_W), .CF(COEF_FRAC_BITS)) u_div_v2 (
        .clk(clk), .n(n2y_reg), .d(w3n), .q(vq2)
    );

    // status and zeroing of error words
    assign sat_any = uq0.sat | vq0.sat | uq1.sat | vq1.sat | uq2.sat | vq2.sat;

    always_comb
    begin
        zero_out = 1'b1;
        if (!seg_flag_reg)
        begin
            status_next = STATUS_NOT_UV;
        end
        else if (zero_w_dly)
        begin
            status_next = STATUS_ZERO_W;
        end
        else
        begin
            zero_out    = 1'b0;
            status_next = sat_any ? STATUS_SAT : STATUS_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg   <= status_next;
        u_value_reg  <= zero_out ? '0 : $signed(uq0.value);
        v_value_reg  <= zero_out ? '0 : $signed(vq0.value);
        u_first_reg  <= zero_out ? '0 : $signed(uq1.value);
        v_first_reg  <= zero_out ? '0 : $signed(vq1.value);
        u_second_reg <= zero_out ? '0 : $signed(uq2.value);
        v_second_reg <= zero_out ? '0 : $signed(vq2.value);
    end

    assign done           = done_reg;
    assign status         = status_reg;
    assign u_value        = u_value_reg;
    assign v_value        = v_value_reg;
    assign u_first_deriv  = u_first_reg;
    assign v_first_deriv  = v_first_reg;
    assign u_second_deriv = u_second_reg;
    assign v_second_deriv = v_second_reg;

    // every accepted word comes out as a done pulse
    `RCUV_ASSERT_AFTER(a_word_out, clk, rst_n, start && !busy, 45, done, "accepted word lost")

    // no result word without an accepted word
    `RCUV_ASSERT_IMPLY(a_no_extra, clk, rst_n, done, $past(start && !busy, 45), "extra word")

    // error words carry zero values
    `RCUV_ASSERT_IMPLY(a_err_zero, clk, rst_n,
        done && (status == STATUS_NOT_UV || status == STATUS_ZERO_W),
        u_value == 0 && v_value == 0 && u_first_deriv == 0 && v_first_deriv == 0 &&
        u_second_deriv == 0 && v_second_deriv == 0, "error word not zero")

endmodule
